FILE: rtl/core/rtpn_pkg.sv
// Shared widths, codes and types of the ring termination node.
package rtpn_pkg;

  // Field and register widths.
  localparam int ID_W       = 6;
  localparam int RS_W       = 7;
  localparam int CNT_W      = 7;
  localparam int KIND_W     = 3;
  localparam int SKIND_W    = 3;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 2;
  localparam int PHASE_W    = 2;
  localparam int ELECT_W    = 7;
  localparam int ALU_W      = 8;
  localparam int BIT_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Defaults and reset values.
  localparam int NODES_DEF = 16;
  localparam logic [RS_W-1:0] RS_RESET = 7'd16;
  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(ID_W - 1);

  // Wave counter codes: done marker and saturation value.
  localparam logic [CNT_W-1:0] CNT_DONE = 7'd127;
  localparam logic [CNT_W-1:0] CNT_SAT  = 7'd126;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 1'b1;

  // Input action codes.
  localparam logic ACT_START = 1'b0;

  // Received message kinds.
  localparam logic [KIND_W-1:0] MSG_REQUEST = 3'd0;
  localparam logic [KIND_W-1:0] MSG_FINAL   = 3'd1;
  localparam logic [KIND_W-1:0] MSG_ACK     = 3'd2;
  localparam logic [KIND_W-1:0] MSG_FIN     = 3'd3;

  // Outgoing message kinds.
  localparam logic [SKIND_W-1:0] SEND_NONE    = 3'd0;
  localparam logic [SKIND_W-1:0] SEND_REQUEST = 3'd1;
  localparam logic [SKIND_W-1:0] SEND_FINAL   = 3'd2;
  localparam logic [SKIND_W-1:0] SEND_ACK     = 3'd3;
  localparam logic [SKIND_W-1:0] SEND_FIN     = 3'd4;

  // Destination modes.
  localparam logic [MODE_W-1:0] DEST_NEXT  = 2'd0;
  localparam logic [MODE_W-1:0] DEST_NAMED = 2'd1;
  localparam logic [MODE_W-1:0] DEST_ALL   = 2'd2;

  // Run status codes.
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_TERMINATED = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNKNOWN    = 2'd2;
  localparam logic [STAT_W-1:0] ST_REJECTED   = 2'd3;

  // Protocol phases.
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RUN  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TERM = 2'd2;

  // One outgoing message without its run status.
  typedef struct packed {
    logic [SKIND_W-1:0] send_kind;
    logic [MODE_W-1:0]  dest_mode;
    logic [ID_W-1:0]    dest_node;
    logic [ID_W-1:0]    send_agent;
  } send_item_t;

  localparam send_item_t ITEM_NONE = '{SEND_NONE, DEST_NEXT, '0, '0};

  // Requests from the sequencer to the output stage.
  typedef struct packed {
    logic              push;
    send_item_t        item;
    logic              finish;
    logic [STAT_W-1:0] status;
  } emit_ctl_t;

  // Room reported by the output stage.
  typedef struct packed {
    logic push_ok;
    logic finish_ok;
  } emit_rdy_t;

endpackage

FILE: rtl/core/rtpn_if.sv
// Valid/ready channel interfaces for incoming items and outgoing results.
interface rtpn_msg_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [rtpn_pkg::KIND_W-1:0]   msg_kind;
  logic [rtpn_pkg::ID_W-1:0]     msg_agent;

  modport source(output valid, action, msg_kind, msg_agent, input ready);
  modport sink(input valid, action, msg_kind, msg_agent, output ready);
endinterface

interface rtpn_res_if;
  logic                          valid;
  logic                          ready;
  logic [rtpn_pkg::SKIND_W-1:0]  send_kind;
  logic [rtpn_pkg::MODE_W-1:0]   dest_mode;
  logic [rtpn_pkg::ID_W-1:0]     dest_node;
  logic [rtpn_pkg::ID_W-1:0]     send_agent;
  logic [rtpn_pkg::STAT_W-1:0]   status;
  logic                          last;

  modport source(output valid, send_kind, dest_mode, dest_node, send_agent, status, last,
                 input ready);
  modport sink(input valid, send_kind, dest_mode, dest_node, send_agent, status, last,
               output ready);
endinterface

FILE: rtl/core/rtpn_emit.sv
// Output stage: holds one pending message and the registered result transfer.
module rtpn_emit (
  input  logic                clk,
  input  logic                rst,
  input  rtpn_pkg::emit_ctl_t ctl,
  output rtpn_pkg::emit_rdy_t rdy,
  rtpn_res_if.source          result
);

  rtpn_pkg::send_item_t          pend;
  logic                          pend_valid;
  rtpn_pkg::send_item_t          out_item;
  logic [rtpn_pkg::STAT_W-1:0]   out_status;
  logic                          out_last;
  logic                          out_valid;
  logic                          out_free;

  // The output register can load when empty or when its transfer completes.
  assign out_free      = !out_valid || result.ready;
  assign rdy.push_ok   = !pend_valid || out_free;
  assign rdy.finish_ok = out_free;

  assign result.valid      = out_valid;
  assign result.send_kind  = out_item.send_kind;
  assign result.dest_mode  = out_item.dest_mode;
  assign result.dest_node  = out_item.dest_node;
  assign result.send_agent = out_item.send_agent;
  assign result.status     = out_status;
  assign result.last       = out_last;

  // A message waits in the pending slot until it is known whether another follows,
  // so that the final one of a run can carry the status and the last mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.finish && out_free) begin
        out_valid  <= 1'b1;
        out_item   <= pend_valid ? pend : rtpn_pkg::ITEM_NONE;
        out_status <= ctl.status;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (ctl.push && rdy.push_ok) begin
        pend       <= ctl.item;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid  <= 1'b1;
          out_item   <= pend;
          out_status <= rtpn_pkg::ST_OK;
          out_last   <= 1'b0;
        end else if (result.ready) begin
          out_valid <= 1'b0;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/ring_termination_protocol_node.sv
// Top level of the ring termination node: sequencer, shared adder and state.
//
// One input item is taken at a time; msg.ready is high only while the sequencer is
// idle and reset is low. Every item passes through accept, decode and a closing
// flush step; a start command, a fin, an unknown kind or a request that is
// forwarded or dropped without a new initiator goes from decode straight to the
// flush. A request that elects a new initiator runs two 6-step remainder
// computations (own node and agent modulo the ring size) and the goal arithmetic,
// with one more addition when the ring distance wraps. A returning own request runs
// one remainder and then its run of n finals. A final or final-ack runs one remainder
// and three checks; the first two can each start a run of outgoing messages, so both
// waves can follow from one input. All arithmetic goes through one 8-bit
// adder/subtractor, and a stall on the result channel holds the sequencer. Results
// leave through a registered output with one pending slot, one transfer per cycle
// while the result channel is ready.
module ring_termination_protocol_node #(
  parameter int NODES = rtpn_pkg::NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rtpn_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rtpn_pkg::CFG_DATA_W-1:0] cfg_data,
  rtpn_msg_if.sink                        msg,
  rtpn_res_if.source                      result
);

  localparam int ID_W    = rtpn_pkg::ID_W;
  localparam int RS_W    = rtpn_pkg::RS_W;
  localparam int CNT_W   = rtpn_pkg::CNT_W;
  localparam int ALU_W   = rtpn_pkg::ALU_W;
  localparam int BIT_W   = rtpn_pkg::BIT_W;
  localparam int ELECT_W = rtpn_pkg::ELECT_W;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_DECODE    = 11'b000_0000_0010,
    S_MOD       = 11'b000_0000_0100,
    S_GOAL_A    = 11'b000_0000_1000,
    S_GOAL_B    = 11'b000_0001_0000,
    S_GOAL_C    = 11'b000_0010_0000,
    S_CHECK_F   = 11'b000_0100_0000,
    S_CHECK_A   = 11'b000_1000_0000,
    S_CHECK_FIN = 11'b001_0000_0000,
    S_SEND      = 11'b010_0000_0000,
    S_FLUSH     = 11'b100_0000_0000
  } state_t;

  // Configuration registers.
  logic [ID_W-1:0]  own_node;
  logic [RS_W-1:0]  ring_size;

  // Protocol state.
  logic [rtpn_pkg::PHASE_W-1:0] phase;
  logic                         started_here;
  logic [ELECT_W-1:0]           elected_agent;
  logic                         first_flag;
  logic                         last_flag;
  logic [CNT_W-1:0]             final_count;
  logic [ID_W-1:0]              final_goal;
  logic [CNT_W-1:0]             ack_count;
  logic [ID_W-1:0]              ack_goal;

  // Sequencer and working registers.
  state_t                       state;
  state_t                       mod_ret;
  state_t                       send_ret;
  logic                         act;
  logic [rtpn_pkg::KIND_W-1:0]  kind;
  logic [ID_W-1:0]              agent;
  logic [rtpn_pkg::STAT_W-1:0]  run_status;
  logic [ID_W-1:0]              rem;
  logic [BIT_W-1:0]             bit_idx;
  logic [ID_W-1:0]              mod_x;
  logic                         mod_is_ini;
  logic                         goals_pend;
  logic [ID_W-1:0]              me;
  logic [ID_W-1:0]              ini;
  logic [ALU_W-1:0]             tmp;
  logic [ID_W-1:0]              to;
  logic [ID_W-1:0]              left;
  logic                         send_up;
  logic [rtpn_pkg::SKIND_W-1:0] send_kind_r;

  // Shared adder/subtractor.
  logic [ALU_W-1:0]             alu_a;
  logic [ALU_W-1:0]             alu_b;
  logic                         alu_inv;
  logic                         alu_cin;
  logic [ALU_W:0]               alu_sum;
  logic [ALU_W-1:0]             alu_res;
  logic                         alu_carry;

  // Derived values.
  logic [RS_W-1:0]              rs;
  logic [ID_W:0]                shifted;
  logic [ID_W-1:0]              rem_new;
  logic [ID_W-1:0]              nxt;
  logic [CNT_W-1:0]             cnt_cur;
  logic [CNT_W-1:0]             bumped;
  logic                         drop_req;
  logic                         fin_now;

  rtpn_pkg::emit_ctl_t          emit_ctl;
  rtpn_pkg::emit_rdy_t          emit_rdy;

  // Effective ring size: zero counts as one, anything above NODES as NODES.
  always_comb begin
    if (ring_size == '0) begin
      rs = RS_W'(1);
    end else if (ring_size > RS_W'(NODES)) begin
      rs = RS_W'(NODES);
    end else begin
      rs = ring_size;
    end
  end

  assign msg.ready = !rst && (state == S_IDLE);

  // Restoring remainder step, one dividend bit per cycle.
  assign shifted = {rem, mod_x[bit_idx]};
  assign rem_new = alu_carry ? alu_res[ID_W-1:0] : shifted[ID_W-1:0];

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_inv = 1'b0;
    alu_cin = 1'b0;
    case (state)
      S_DECODE: begin
        if (kind == rtpn_pkg::MSG_REQUEST) begin
          alu_a   = ALU_W'(rs);
          alu_inv = 1'b1;
        end else begin
          alu_a   = ALU_W'(cnt_cur);
          alu_cin = 1'b1;
        end
      end
      S_MOD: begin
        alu_a   = ALU_W'(shifted);
        alu_b   = ALU_W'(rs);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_GOAL_A: begin
        alu_a   = ALU_W'(me);
        alu_b   = ALU_W'(ini);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_GOAL_B: begin
        alu_a = tmp;
        alu_b = ALU_W'(rs);
      end
      S_GOAL_C: begin
        alu_a   = ALU_W'(rs);
        alu_b   = ALU_W'(final_goal);
        alu_inv = 1'b1;
      end
      S_SEND: begin
        if (send_up) begin
          alu_a   = ALU_W'(to);
          alu_cin = 1'b1;
        end else begin
          alu_a   = (to == '0) ? ALU_W'(rs) : ALU_W'(to);
          alu_inv = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_inv ? ~alu_b : alu_b)}
                   + {{ALU_W{1'b0}}, alu_cin};
  assign alu_res   = alu_sum[ALU_W-1:0];
  assign alu_carry = alu_sum[ALU_W];

  // Next destination around the ring, wrapping at the ring size.
  always_comb begin
    if (send_up && (alu_res[RS_W-1:0] == rs)) begin
      nxt = '0;
    end else begin
      nxt = alu_res[ID_W-1:0];
    end
  end

  // Wave counter bump: done restarts at zero, otherwise count up and saturate.
  assign cnt_cur = (kind == rtpn_pkg::MSG_FINAL) ? final_count : ack_count;
  always_comb begin
    if (cnt_cur == rtpn_pkg::CNT_DONE) begin
      bumped = '0;
    end else if (cnt_cur < rtpn_pkg::CNT_SAT) begin
      bumped = alu_res[CNT_W-1:0];
    end else begin
      bumped = rtpn_pkg::CNT_SAT;
    end
  end

  assign drop_req = started_here && (agent > own_node);
  assign fin_now  = (ack_count == rtpn_pkg::CNT_DONE) &&
                    (final_count == rtpn_pkg::CNT_DONE) && first_flag;

  // Messages and run completion handed to the output stage.
  always_comb begin
    emit_ctl        = '0;
    emit_ctl.status = run_status;
    case (state)
      S_DECODE: begin
        if (act == rtpn_pkg::ACT_START) begin
          if (phase == rtpn_pkg::PH_IDLE) begin
            emit_ctl.push = 1'b1;
            emit_ctl.item = '{rtpn_pkg::SEND_REQUEST, rtpn_pkg::DEST_NEXT, '0, own_node};
          end
        end else if ((kind == rtpn_pkg::MSG_REQUEST) && (agent != own_node) && !drop_req)
        begin
          emit_ctl.push = 1'b1;
          emit_ctl.item = '{rtpn_pkg::SEND_REQUEST, rtpn_pkg::DEST_NEXT, '0, agent};
        end
      end
      S_SEND: begin
        if (left != '0) begin
          emit_ctl.push = 1'b1;
          emit_ctl.item = '{send_kind_r, rtpn_pkg::DEST_NAMED, nxt, '0};
        end
      end
      S_CHECK_FIN: begin
        if (fin_now) begin
          emit_ctl.push = 1'b1;
          emit_ctl.item = '{rtpn_pkg::SEND_FIN, rtpn_pkg::DEST_ALL, '0, '0};
        end
      end
      S_FLUSH: begin
        emit_ctl.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, protocol state and configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      own_node      <= '0;
      ring_size     <= rtpn_pkg::RS_RESET;
      phase         <= rtpn_pkg::PH_IDLE;
      started_here  <= 1'b0;
      elected_agent <= ELECT_W'(NODES);
      first_flag    <= 1'b0;
      last_flag     <= 1'b0;
      final_count   <= '0;
      final_goal    <= '0;
      ack_count     <= '0;
      ack_goal      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          rtpn_pkg::REG_OWN_NODE:  own_node  <= cfg_data[ID_W-1:0];
          rtpn_pkg::REG_RING_SIZE: ring_size <= cfg_data[RS_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (msg.valid) begin
            act        <= msg.action;
            kind       <= msg.msg_kind;
            agent      <= msg.msg_agent;
            run_status <= rtpn_pkg::ST_OK;
            state      <= S_DECODE;
          end
        end

        // The pending slot is always empty here, so a push is always taken.
        S_DECODE: begin
          rem        <= '0;
          bit_idx    <= rtpn_pkg::BIT_TOP;
          mod_x      <= own_node;
          mod_is_ini <= 1'b0;
          goals_pend <= 1'b0;
          if (act == rtpn_pkg::ACT_START) begin
            if (phase != rtpn_pkg::PH_IDLE) begin
              run_status <= rtpn_pkg::ST_REJECTED;
            end else begin
              phase        <= rtpn_pkg::PH_RUN;
              started_here <= 1'b1;
            end
            state <= S_FLUSH;
          end else begin
            case (kind)
              rtpn_pkg::MSG_REQUEST: begin
                phase <= rtpn_pkg::PH_RUN;
                if (agent == own_node) begin
                  // Own request came back: this node starts the final wave.
                  elected_agent <= ELECT_W'(agent);
                  first_flag    <= 1'b1;
                  last_flag     <= 1'b0;
                  final_count   <= '0;
                  ack_count     <= '0;
                  final_goal    <= '0;
                  ack_goal      <= alu_res[ID_W-1:0];
                  left          <= alu_res[ID_W-1:0];
                  send_up       <= 1'b1;
                  send_kind_r   <= rtpn_pkg::SEND_FINAL;
                  send_ret      <= S_FLUSH;
                  mod_ret       <= S_SEND;
                  state         <= S_MOD;
                end else if (drop_req) begin
                  state <= S_FLUSH;
                end else if (ELECT_W'(agent) < elected_agent) begin
                  // New lowest initiator: recompute ring goals.
                  elected_agent <= ELECT_W'(agent);
                  first_flag    <= 1'b0;
                  final_count   <= '0;
                  ack_count     <= '0;
                  goals_pend    <= 1'b1;
                  state         <= S_MOD;
                end else begin
                  state <= S_FLUSH;
                end
              end
              rtpn_pkg::MSG_FINAL: begin
                final_count <= bumped;
                mod_ret     <= S_CHECK_F;
                state       <= S_MOD;
              end
              rtpn_pkg::MSG_ACK: begin
                ack_count <= bumped;
                mod_ret   <= S_CHECK_F;
                state     <= S_MOD;
              end
              rtpn_pkg::MSG_FIN: begin
                phase      <= rtpn_pkg::PH_TERM;
                run_status <= rtpn_pkg::ST_TERMINATED;
                state      <= S_FLUSH;
              end
              default: begin
                run_status <= rtpn_pkg::ST_UNKNOWN;
                state      <= S_FLUSH;
              end
            endcase
          end
        end

        // Remainder of own node, and then of the agent when goals are due.
        S_MOD: begin
          rem <= rem_new;
          if (bit_idx != '0) begin
            bit_idx <= bit_idx - BIT_W'(1);
          end else if (!mod_is_ini) begin
            me <= rem_new;
            to <= rem_new;
            if (goals_pend) begin
              mod_is_ini <= 1'b1;
              rem        <= '0;
              bit_idx    <= rtpn_pkg::BIT_TOP;
              mod_x      <= agent;
            end else begin
              state <= mod_ret;
            end
          end else begin
            ini   <= rem_new;
            state <= S_GOAL_A;
          end
        end

        // Final goal is the ring distance from the initiator to this node.
        S_GOAL_A: begin
          if (alu_carry) begin
            final_goal <= alu_res[ID_W-1:0];
            state      <= S_GOAL_C;
          end else begin
            tmp   <= alu_res;
            state <= S_GOAL_B;
          end
        end

        S_GOAL_B: begin
          final_goal <= alu_res[ID_W-1:0];
          state      <= S_GOAL_C;
        end

        S_GOAL_C: begin
          ack_goal  <= alu_res[ID_W-1:0];
          last_flag <= (alu_res[ID_W-1:0] == '0);
          state     <= S_FLUSH;
        end

        // Final wave complete: pass finals on, or turn acks back at the last node.
        S_CHECK_F: begin
          state <= S_CHECK_A;
          if (final_count == CNT_W'(final_goal)) begin
            final_count <= rtpn_pkg::CNT_DONE;
            if (last_flag) begin
              left        <= final_goal;
              send_up     <= 1'b0;
              send_kind_r <= rtpn_pkg::SEND_ACK;
              to          <= me;
              send_ret    <= S_CHECK_A;
              state       <= S_SEND;
            end else if (!first_flag) begin
              left        <= ack_goal;
              send_up     <= 1'b1;
              send_kind_r <= rtpn_pkg::SEND_FINAL;
              to          <= me;
              send_ret    <= S_CHECK_A;
              state       <= S_SEND;
            end
          end
        end

        // Ack wave complete: inner nodes send acks back toward the initiator.
        S_CHECK_A: begin
          state <= S_CHECK_FIN;
          if (ack_count == CNT_W'(ack_goal)) begin
            ack_count <= rtpn_pkg::CNT_DONE;
            if (!first_flag && !last_flag) begin
              left        <= final_goal;
              send_up     <= 1'b0;
              send_kind_r <= rtpn_pkg::SEND_ACK;
              to          <= me;
              send_ret    <= S_CHECK_FIN;
              state       <= S_SEND;
            end
          end
        end

        // Both waves done at the initiator: broadcast fin and terminate.
        S_CHECK_FIN: begin
          if (fin_now) begin
            if (emit_rdy.push_ok) begin
              phase      <= rtpn_pkg::PH_TERM;
              run_status <= rtpn_pkg::ST_TERMINATED;
              state      <= S_FLUSH;
            end
          end else begin
            state <= S_FLUSH;
          end
        end

        // One message per cycle, while the output stage has room, to successive nodes around the ring.
        S_SEND: begin
          if (left == '0) begin
            state <= send_ret;
          end else if (emit_rdy.push_ok) begin
            to   <= nxt;
            left <= left - ID_W'(1);
          end
        end

        S_FLUSH: begin
          if (emit_rdy.finish_ok) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rtpn_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (emit_ctl),
    .rdy    (emit_rdy),
    .result (result)
  );

endmodule
